/* sv/bounded_array_list_engine_macros.svh */
// Assertion macros shared by the list engine RTL.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define BALE_ASSERT_ALWAYS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("list engine check failed");
// Check that a consequence holds in the same cycle as its trigger.
`define BALE_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("list engine check failed");
`else
`define BALE_ASSERT_ALWAYS(lbl, ck, rs, cond)
`define BALE_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`endif

`endif

/* sv/bale_pkg.sv */
// Shared types and codes for the bounded list engine.
package bale_pkg;

  // Action codes carried by a request transaction
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_LOCATE = 3'd3;
  localparam logic [2:0] ACT_SORTED = 3'd4;

  // Status codes returned with each response
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int DATA_W = 32;
  localparam int FIELD_W = 5;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_OPEN,
    OP_CLOSE,
    OP_CMP_EQ,
    OP_CMP_GT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

/* sv/bounded_array_list_engine.sv */
// Top level of the bounded list engine: sequencer plus a chain of slot cells.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | action, position, data_value
//   rsp     | rsp_valid/rsp_ready  | status, location, entry_count
//
// Clear, insert, delete and unused actions go from idle straight to the commit step.
// Locate and sorted insert compare in every cell at once, then shift the match
// flags one cell per cycle toward slot zero, until a hit reaches slot zero or
// the scan has passed every entry.
// Reset empties the list at once; no clearing pass. A stalled response holds
// the sequencer in its commit step; the next request is taken once it lands.
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [2:0]               action,
  input  logic [FIELD_W-1:0]       position,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [1:0]               status,
  output logic [FIELD_W-1:0]       location,
  output logic [FIELD_W-1:0]       entry_count
);

`include "bounded_array_list_engine_macros.svh"

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  cell_cmd_t                cmd;
  logic [IDX_W-1:0]         target;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] entry [CAPACITY];
  logic                     flag [CAPACITY];

  // Sequencer
  bale_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .action     (action),
    .position   (position),
    .data_value (data_value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .location   (location),
    .entry_count(entry_count),
    .cmd        (cmd),
    .target     (target),
    .count      (count),
    .flag_head  (flag[0])
  );

  // Chain of slot cells; the end entries tie back to themselves, the last next flag is zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_entry;
    logic signed [DATA_W-1:0] next_entry;
    logic                     next_flag;

    if (i == 0) begin : g_first
      assign prev_entry = entry[0];
    end else begin : g_mid_lo
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
      assign next_flag  = 1'b0;
    end else begin : g_mid_hi
      assign next_entry = entry[i+1];
      assign next_flag  = flag[i+1];
    end

    bale_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .target    (target),
      .count     (count),
      .prev_entry(prev_entry),
      .next_entry(next_entry),
      .next_flag (next_flag),
      .entry     (entry[i]),
      .flag      (flag[i])
    );
  end

  // Checks on the sequencer and the cell commands
  `BALE_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CAP_CNT)
  `BALE_ASSERT_IMPLY(a_open_room, clk, rst, cmd.op == OP_OPEN, count < CAP_CNT)
  `BALE_ASSERT_IMPLY(a_close_nonempty, clk, rst, cmd.op == OP_CLOSE, count != '0)

endmodule

/* sv/bale_cell.sv */
// One slot of the list: holds an entry and a match flag, talks to its neighbors.
module bale_cell import bale_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic [$clog2(CAPACITY)-1:0]   target,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic signed [DATA_W-1:0] prev_entry,
  input  logic signed [DATA_W-1:0] next_entry,
  input  logic                     next_flag,
  output logic signed [DATA_W-1:0] entry,
  output logic                     flag
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  // Shift the entry up on open, down on close, or load the new value
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_OPEN: begin
        if (MY_IDX > target) begin
          entry <= prev_entry;
        end else if (MY_IDX == target) begin
          entry <= cmd.value;
        end
      end
      OP_CLOSE: begin
        if (MY_IDX >= target) begin
          entry <= next_entry;
        end
      end
      default: ;
    endcase
  end

  // Compare against the broadcast value, then hand flags toward slot zero
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CMP_EQ: flag <= (MY_CNT < count) && (entry == cmd.value);
        OP_CMP_GT: flag <= (MY_CNT < count) && (entry > cmd.value);
        OP_SHIFT:  flag <= next_flag;
        default: ;
      endcase
    end
  end

endmodule

/* sv/bale_ctrl.sv */
// Sequencer: takes requests, drives the cell chain, and registers responses.
module bale_ctrl import bale_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [2:0]               action,
  input  logic [FIELD_W-1:0]       position,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [1:0]               status,
  output logic [FIELD_W-1:0]       location,
  output logic [FIELD_W-1:0]       entry_count,
  output cell_cmd_t                cmd,
  output logic [$clog2(CAPACITY)-1:0]   target,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic                     flag_head
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t                   state, state_next;
  logic [2:0]               act;
  logic [FIELD_W-1:0]       pos;
  logic signed [DATA_W-1:0] value;
  logic [CNT_W-1:0]         scan_idx;
  logic                     found;
  logic                     scan_done;
  logic                     commit_go;
  logic [CNT_W-1:0]         count_next;
  logic [1:0]               status_next;
  logic [PW-1:0]            loc_next;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [PW-1:0]            cnt_next_ext;
  logic [CNT_W-1:0]         sorted_at;

  assign pos_ext = PW'(pos);
  assign cnt_ext = PW'(count);
  assign scan_done = flag_head || ((scan_idx + CNT_W'(1)) >= count);
  assign commit_go = (state == S_COMMIT) && (!rsp_valid || rsp_ready);
  assign sorted_at = found ? scan_idx : count;
  assign cnt_next_ext = PW'(count_next);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (action == ACT_LOCATE || action == ACT_SORTED) begin
            state_next = S_COMPARE;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_COMPARE: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: cell commands and the result of the pending action
  always_comb begin
    req_ready   = (state == S_IDLE);
    cmd.op      = OP_HOLD;
    cmd.value   = value;
    target      = '0;
    count_next  = count;
    status_next = ST_OK;
    loc_next    = '0;
    unique case (state)
      S_COMPARE: cmd.op = (act == ACT_LOCATE) ? OP_CMP_EQ : OP_CMP_GT;
      S_SCAN:    cmd.op = OP_SHIFT;
      S_COMMIT: begin
        unique case (act)
          ACT_CLEAR: count_next = '0;
          ACT_INSERT: begin
            if (pos_ext > cnt_ext) begin
              status_next = ST_BAD_POS;
            end else if (count == CAP_CNT) begin
              status_next = ST_FULL;
            end else begin
              cmd.op     = commit_go ? OP_OPEN : OP_HOLD;
              target     = pos_ext[IDX_W-1:0];
              count_next = count + CNT_W'(1);
            end
          end
          ACT_DELETE: begin
            if (pos_ext >= cnt_ext) begin
              status_next = ST_BAD_POS;
            end else begin
              cmd.op     = commit_go ? OP_CLOSE : OP_HOLD;
              target     = pos_ext[IDX_W-1:0];
              count_next = count - CNT_W'(1);
            end
          end
          ACT_LOCATE: begin
            if (found) begin
              loc_next = PW'(scan_idx) + PW'(1);
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          ACT_SORTED: begin
            if (count == CAP_CNT) begin
              status_next = ST_FULL;
            end else begin
              cmd.op     = commit_go ? OP_OPEN : OP_HOLD;
              target     = sorted_at[IDX_W-1:0];
              count_next = count + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the request, track the scan, and load the response
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      act   <= action;
      pos   <= position;
      value <= data_value;
    end
    if (state == S_COMPARE) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      if (flag_head) begin
        found <= 1'b1;
      end else if (!scan_done) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
    end
    if (commit_go) begin
      status      <= status_next;
      location    <= loc_next[FIELD_W-1:0];
      entry_count <= cnt_next_ext[FIELD_W-1:0];
    end
  end

endmodule

/* tb/tb_bounded_array_list_engine.sv */
// Self-checking testbench for the bounded list engine, predicted against its own list copy.
module tb_bounded_array_list_engine;
  import bale_pkg::*;

  localparam int LIST_CAPACITY = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 30;
  localparam int RANDOM_ITEMS  = 1900;

  // Action codes the engine ignores
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] location;
    logic [FIELD_W-1:0] entry_count;
  } list_rsp_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  logic [2:0]               action = ACT_CLEAR;
  logic [FIELD_W-1:0]       position = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  logic [1:0]               status;
  logic [FIELD_W-1:0]       location;
  logic [FIELD_W-1:0]       entry_count;

  // Shadow copy of the list and the responses still owed by the engine
  logic signed [DATA_W-1:0] list_vals [LIST_CAPACITY];
  int                       list_len = 0;
  list_rsp_t                expected_rsp_q[$];

  int fail_count      = 0;
  int send_idle_pct   = 0;
  int rcv_stall_pct   = 0;
  int rsp_hold_cycles = 0;
  int quiet_cycles    = 0;
  bit grow_phase      = 1'b1;

  bounded_array_list_engine #(.CAPACITY(LIST_CAPACITY)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .action      (action),
    .position    (position),
    .data_value  (data_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .location    (location),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move entries at and above slot up by one, then place the value
  function automatic void open_list_slot(int slot, logic signed [DATA_W-1:0] val);
    for (int i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
    list_vals[slot] = val;
    list_len++;
  endfunction

  // Apply one action to the shadow list and return the response it must produce
  function automatic list_rsp_t apply_list_action(logic [2:0] act, logic [FIELD_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
    list_rsp_t rsp;
    int        slot;
    rsp.status   = ST_OK;
    rsp.location = '0;
    case (act)
      ACT_CLEAR: list_len = 0;
      ACT_INSERT: begin
        if (pos > list_len) rsp.status = ST_BAD_POS;
        else if (list_len >= LIST_CAPACITY) rsp.status = ST_FULL;
        else open_list_slot(int'(pos), val);
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          rsp.status = ST_BAD_POS;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      ACT_LOCATE: begin
        rsp.status = ST_NOT_FOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) begin
            rsp.status   = ST_OK;
            rsp.location = FIELD_W'(i + 1);
            break;
          end
        end
      end
      ACT_SORTED: begin
        if (list_len >= LIST_CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          slot = list_len;
          for (int i = 0; i < list_len; i++) begin
            if (list_vals[i] > val) begin
              slot = i;
              break;
            end
          end
          open_list_slot(slot, val);
        end
      end
      default: ;
    endcase
    rsp.entry_count = FIELD_W'(list_len);
    return rsp;
  endfunction

  // Predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready)
        expected_rsp_q.push_back(apply_list_action(action, position, data_value));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (location !== want.location) begin
            $error("location: expected %0d, got %0d", want.location, location);
            fail_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  // Drive response ready: forced hold-off first, random stalls otherwise
  always @(posedge clk) begin
    if (rsp_hold_cycles > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold_cycles--;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bounded_array_list_engine verification failed");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic [2:0] act, input logic [FIELD_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    action     <= act;
    position   <= pos;
    data_value <= val;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed response has arrived; the extra edge
  // lets the last accepted request land in the queue first
  task automatic wait_for_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Build and send one random request, drifting between growing and shrinking
  task automatic send_random_item();
    logic [2:0]               act;
    logic [FIELD_W-1:0]       pos;
    logic signed [DATA_W-1:0] val;
    int                       len;
    int                       r;
    len = list_len;
    if ($urandom_range(39) == 0) grow_phase = !grow_phase;
    r = $urandom_range(99);
    if (r < 2) act = ACT_CLEAR;
    else if (r < 4) act = 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    else if (grow_phase) act = (r < 34) ? ACT_INSERT : (r < 64) ? ACT_SORTED :
                               (r < 84) ? ACT_LOCATE : ACT_DELETE;
    else act = (r < 16) ? ACT_INSERT : (r < 28) ? ACT_SORTED :
               (r < 58) ? ACT_LOCATE : ACT_DELETE;
    r = $urandom_range(99);
    if (r < 80) pos = FIELD_W'($urandom_range(len));
    else if (r < 95) pos = FIELD_W'($urandom_range(LIST_CAPACITY));
    else pos = FIELD_W'($urandom);
    r = $urandom_range(99);
    if (r < 40 && len > 0) begin
      val = list_vals[$urandom_range(len - 1)];
    end else if (r < 55) begin
      val = int'($urandom_range(6)) - 3;
    end else if (r < 62) begin
      case ($urandom_range(3))
        0: val = VAL_MAX;
        1: val = VAL_MIN;
        2: val = '0;
        default: val = '1;
      endcase
    end else begin
      val = $urandom;
    end
    send_request(act, pos, val);
  endtask

  // Every action and the boundary cases on a short list
  task automatic test_basic_actions();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    send_request(ACT_CLEAR, 0, 0);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_LOCATE, 0, 5);
    send_request(ACT_INSERT, 0, VAL_MAX);
    send_request(ACT_INSERT, 0, VAL_MIN);
    send_request(ACT_INSERT, 3, 7);
    send_request(ACT_INSERT, 2, 0);
    send_request(ACT_INSERT, 1, -1);
    send_request(ACT_SORTED, 0, 0);
    send_request(ACT_SORTED, 0, 0);
    send_request(ACT_LOCATE, 0, 0);
    send_request(ACT_LOCATE, 0, 12345);
    send_request(ACT_DELETE, 6, 0);
    send_request(ACT_DELETE, 31, 0);
    send_request(ACT_DELETE, 0, 0);
    send_request(ACT_DELETE, 4, 0);
    send_request(ACT_INSERT, 31, 9);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) send_request(3'(a), 16, VAL_MIN);
    send_request(ACT_CLEAR, 0, 0);
    send_request(ACT_LOCATE, 0, 0);
  endtask

  // Fill the list to capacity and probe the full-list refusals
  task automatic test_full_list();
    send_request(ACT_CLEAR, 0, 0);
    for (int i = 0; i < LIST_CAPACITY - 1; i++) send_request(ACT_SORTED, 0, (i % 5) * 100 - 200);
    send_request(ACT_SORTED, 0, VAL_MAX);
    send_request(ACT_INSERT, 16, 1);
    send_request(ACT_INSERT, 17, 1);
    send_request(ACT_SORTED, 0, VAL_MIN);
    send_request(ACT_LOCATE, 0, VAL_MAX);
    send_request(ACT_DELETE, 16, 0);
    send_request(ACT_DELETE, 15, 0);
    send_request(ACT_DELETE, 0, 0);
  endtask

  // Hold off responses for a long stretch while requests keep coming
  task automatic test_receiver_hold_off();
    send_idle_pct   = 0;
    rcv_stall_pct   = 0;
    rsp_hold_cycles = 150;
    repeat (12) send_random_item();
  endtask

  // Pause the sender until the engine has answered everything
  task automatic test_sender_pause();
    send_idle_pct = 26;
    rcv_stall_pct = 26;
    repeat (20) send_random_item();
    wait_for_responses();
    repeat (20) send_random_item();
  endtask

  // Random traffic under each idling mix
  task automatic test_random_traffic();
    int phase_items;
    phase_items = RANDOM_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 81; end
        default: begin send_idle_pct = 26; rcv_stall_pct = 26; end
      endcase
      repeat (phase_items) send_random_item();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_actions();
    test_full_list();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_traffic();
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("bounded_array_list_engine verification clean");
    else $display("bounded_array_list_engine verification failed");
    $finish;
  end

endmodule
